// ===== rtl/obvg_pkg.sv =====
// ============================================================================
// obvg_pkg
// Shared types, constants and the arctangent table for the box corner
// generator.
// ============================================================================
package obvg_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int NSTEPS     = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

   typedef struct packed {
      logic                kind;
      logic signed [31:0]  ref_x;
      logic signed [31:0]  ref_y;
      logic [15:0]         heading;
      logic [15:0]         box_length;
      logic [15:0]         box_width;
      logic [15:0]         front_overhang;
      logic [15:0]         box_height;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  vertex_x;
      logic signed [31:0]  vertex_y;
      logic [15:0]         vertex_z;
      logic [2:0]          vertex_index;
      logic                last;
   } rsp_type;

   // Box job handed from the front (angle) to the back (corner emitter).
   typedef struct packed {
      logic signed [31:0]  ref_x;
      logic signed [31:0]  ref_y;
      logic signed [31:0]  cos_v;   // Q1.30 clamped
      logic signed [31:0]  sin_v;
      logic signed [17:0]  s_front; // 2*s
      logic signed [17:0]  s_rear;
      logic signed [17:0]  t_wid;   // 2*t
      logic [15:0]         box_height;
   } job_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:  atan_turn = 34'sd536870912;
         5'd1:  atan_turn = 34'sd316933406;
         5'd2:  atan_turn = 34'sd167458907;
         5'd3:  atan_turn = 34'sd85004756;
         5'd4:  atan_turn = 34'sd42667331;
         5'd5:  atan_turn = 34'sd21354465;
         5'd6:  atan_turn = 34'sd10679838;
         5'd7:  atan_turn = 34'sd5340245;
         5'd8:  atan_turn = 34'sd2670163;
         5'd9:  atan_turn = 34'sd1335087;
         5'd10: atan_turn = 34'sd667544;
         5'd11: atan_turn = 34'sd333772;
         5'd12: atan_turn = 34'sd166886;
         5'd13: atan_turn = 34'sd83443;
         5'd14: atan_turn = 34'sd41722;
         5'd15: atan_turn = 34'sd20861;
         5'd16: atan_turn = 34'sd10430;
         5'd17: atan_turn = 34'sd5215;
         5'd18: atan_turn = 34'sd2608;
         5'd19: atan_turn = 34'sd1304;
         5'd20: atan_turn = 34'sd652;
         5'd21: atan_turn = 34'sd326;
         5'd22: atan_turn = 34'sd163;
         5'd23: atan_turn = 34'sd81;
         5'd24: atan_turn = 34'sd41;
         5'd25: atan_turn = 34'sd20;
         5'd26: atan_turn = 34'sd10;
         5'd27: atan_turn = 34'sd5;
         5'd28: atan_turn = 34'sd3;
         5'd29: atan_turn = 34'sd1;
         default: atan_turn = 34'sd0;
      endcase
   endfunction

endpackage

// ===== rtl/obvg_cordic_stage.sv =====
// ============================================================================
// obvg_cordic_stage
// One registered CORDIC rotation step with sideband carry.
// ============================================================================
module obvg_cordic_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              step,
   input  logic                    in_valid,
   input  logic                    advance,
   input  logic signed [33:0]      x_in,
   input  logic signed [33:0]      y_in,
   input  logic signed [33:0]      z_in,
   input  logic [1:0]              quad_in,
   input  obvg_pkg::req_type       item_in,
   output logic                    out_valid,
   output logic signed [33:0]      x_out,
   output logic signed [33:0]      y_out,
   output logic signed [33:0]      z_out,
   output logic [1:0]              quad_out,
   output obvg_pkg::req_type       item_out
);
   import obvg_pkg::*;

   logic                valid_ff;
   logic signed [33:0]  x_ff, y_ff, z_ff, x_in_n, y_in_n, z_in_n;
   logic [1:0]          quad_ff;
   req_type             item_ff;

   // rotate toward zero residual angle
   always_comb begin
      if (!z_in[33]) begin
         x_in_n = x_in - (y_in >>> step);
         y_in_n = y_in + (x_in >>> step);
         z_in_n = z_in - atan_turn(step);
      end else begin
         x_in_n = x_in + (y_in >>> step);
         y_in_n = y_in - (x_in >>> step);
         z_in_n = z_in + atan_turn(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         quad_ff <= quad_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign quad_out  = quad_ff;
   assign item_out  = item_ff;
endmodule

// ===== rtl/obvg_front.sv =====
// ============================================================================
// obvg_front
// Accepts boxes, runs a 30-stage CORDIC pipeline and classifies the offsets.
// ============================================================================
module obvg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  obvg_pkg::req_type  req_data,
   output logic               job_valid,
   input  logic               job_ready,
   output obvg_pkg::job_type  job_data
);
   import obvg_pkg::*;

   logic signed [33:0] xs [0:NSTEPS];
   logic signed [33:0] ys [0:NSTEPS];
   logic signed [33:0] zs [0:NSTEPS];
   logic [1:0]         qs [0:NSTEPS];
   req_type            its [0:NSTEPS];
   logic               vs [0:NSTEPS];
   logic               advance;
   logic [31:0]        turn;
   logic signed [33:0] cc, ss, cc_cl, ss_cl;
   req_type            it;
   logic               out_valid_ff;
   job_type            job_ff, job_in;

   // the pipeline moves when its output slot is free or being drained
   assign advance = !out_valid_ff || job_ready;
   assign full    = !advance;

   assign turn  = {req_data.heading[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
   assign xs[0] = CORDIC_GAIN;
   assign ys[0] = '0;
   assign zs[0] = {4'd0, turn[29:0]};
   assign qs[0] = turn[31:30];
   assign its[0] = req_data;
   assign vs[0] = push;

   for (genvar g = 0; g < NSTEPS; g++) begin : g_stage
      obvg_cordic_stage u_stage (
         .clock(clock), .reset(reset), .step(5'(g)),
         .in_valid(vs[g]), .advance(advance),
         .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]), .quad_in(qs[g]),
         .item_in(its[g]),
         .out_valid(vs[g+1]),
         .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]),
         .quad_out(qs[g+1]), .item_out(its[g+1])
      );
   end

   // fold quadrant, clamp, and form doubled offsets
   always_comb begin
      it = its[NSTEPS];
      case (qs[NSTEPS])
         2'd0:    begin cc = xs[NSTEPS];  ss = ys[NSTEPS];  end
         2'd1:    begin cc = -ys[NSTEPS]; ss = xs[NSTEPS];  end
         2'd2:    begin cc = -xs[NSTEPS]; ss = -ys[NSTEPS]; end
         default: begin cc = ys[NSTEPS];  ss = -xs[NSTEPS]; end
      endcase
      cc_cl = (cc > ONE_Q30) ? ONE_Q30 : ((cc < -ONE_Q30) ? -ONE_Q30 : cc);
      ss_cl = (ss > ONE_Q30) ? ONE_Q30 : ((ss < -ONE_Q30) ? -ONE_Q30 : ss);
      job_in.ref_x = it.ref_x;
      job_in.ref_y = it.ref_y;
      job_in.cos_v = cc_cl[31:0];
      job_in.sin_v = ss_cl[31:0];
      job_in.t_wid = $signed({2'b00, it.box_width});
      job_in.box_height = it.box_height;
      if (!it.kind) begin
         job_in.s_front = $signed({2'b00, it.box_length});
         job_in.s_rear  = -$signed({2'b00, it.box_length});
      end else begin
         job_in.s_front = $signed({1'b0, it.front_overhang, 1'b0});
         job_in.s_rear  = $signed({1'b0, it.front_overhang, 1'b0})
                          - $signed({1'b0, it.box_length, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vs[NSTEPS];
      end
      if (advance) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = out_valid_ff;
   assign job_data  = job_ff;
endmodule

// ===== rtl/obvg_job_queue.sv =====
// ============================================================================
// obvg_job_queue
// Short queue of box jobs between the angle front and the corner back.
// ============================================================================
module obvg_job_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  obvg_pkg::job_type  wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output obvg_pkg::job_type  rd_data
);
   import obvg_pkg::*;

   job_type    mem_ff [0:3];
   logic [1:0] wptr_ff, rptr_ff;
   logic [2:0] cnt_ff;
   logic       wr_en, rd_en;

   assign wr_ready = (cnt_ff != 3'd4);
   assign rd_valid = (cnt_ff != 3'd0);
   assign wr_en    = wr_valid && wr_ready;
   assign rd_en    = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rptr_ff];

   // advance pointers and count on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr_en) wptr_ff <= wptr_ff + 2'd1;
         if (rd_en) rptr_ff <= rptr_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, wr_en} - {2'b0, rd_en};
      end
      if (wr_en) mem_ff[wptr_ff] <= wr_data;
   end
endmodule

// ===== rtl/obvg_back.sv =====
// ============================================================================
// obvg_back
// Emits the eight corners of each job, one per cycle while the output queue
// has room, through a multiply stage and the output queue the place logic writes.
// ============================================================================
module obvg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  obvg_pkg::job_type  job_data,
   output logic               empty,
   input  logic               pop,
   output obvg_pkg::rsp_type  rsp_data
);
   import obvg_pkg::*;

   logic [2:0]          k_ff;
   logic                issue;
   logic signed [17:0]  sv, tv;
   // stage 1: products
   logic                p_valid_ff;
   logic signed [49:0]  sc_ff, ts_ff, ss_ff, tc_ff;
   logic signed [31:0]  rx1_ff, ry1_ff;
   logic [15:0]         z1_ff;
   logic [2:0]          k1_ff;
   // stage 2: result skid queue
   rsp_type             q_ff [0:3];
   logic [1:0]          qw_ff, qr_ff;
   logic [2:0]          qc_ff;
   logic [2:0]          inflight;
   logic                q_wr, q_rd;
   logic signed [51:0]  px, py;
   rsp_type             r_in;

   // stall issue while the queue could not absorb what is in flight
   assign inflight  = qc_ff + {2'b0, p_valid_ff};
   assign issue     = job_valid && (inflight < 3'd3 || (inflight == 3'd3 && q_rd));
   assign job_ready = issue && (k_ff == 3'd7);

   always_comb begin
      case (k_ff[1:0])
         2'd0:    begin sv = job_data.s_front; tv = job_data.t_wid;  end
         2'd1:    begin sv = job_data.s_front; tv = -job_data.t_wid; end
         2'd2:    begin sv = job_data.s_rear;  tv = -job_data.t_wid; end
         default: begin sv = job_data.s_rear;  tv = job_data.t_wid;  end
      endcase
   end

   function automatic logic signed [31:0] place(input logic signed [31:0] r,
                                                input logic signed [51:0] p);
      logic signed [51:0] d, v;
      d = (p + 52'sd1073741824) >>> 31;
      v = d + 52'(r);
      if (v > 52'sd2147483647)       place = 32'sh7fffffff;
      else if (v < -52'sd2147483648) place = 32'sh80000000;
      else                           place = v[31:0];
   endfunction

   always_comb begin
      px = 52'(sc_ff) - 52'(ts_ff);
      py = 52'(ss_ff) + 52'(tc_ff);
      r_in.vertex_x     = place(rx1_ff, px);
      r_in.vertex_y     = place(ry1_ff, py);
      r_in.vertex_z     = k1_ff[2] ? z1_ff : 16'd0;
      r_in.vertex_index = k1_ff;
      r_in.last         = (k1_ff == 3'd7);
   end

   assign q_wr     = p_valid_ff;
   assign q_rd     = pop && !empty;
   assign empty    = (qc_ff == 3'd0);
   assign rsp_data = q_ff[qr_ff];

   // step the corner counter and pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= '0;
         p_valid_ff <= 1'b0;
         qw_ff      <= '0;
         qr_ff      <= '0;
         qc_ff      <= '0;
      end else begin
         if (issue) k_ff <= k_ff + 3'd1;
         p_valid_ff <= issue;
         if (q_wr) qw_ff <= qw_ff + 2'd1;
         if (q_rd) qr_ff <= qr_ff + 2'd1;
         qc_ff <= qc_ff + {2'b0, q_wr} - {2'b0, q_rd};
      end
      sc_ff  <= sv * job_data.cos_v;
      ts_ff  <= tv * job_data.sin_v;
      ss_ff  <= sv * job_data.sin_v;
      tc_ff  <= tv * job_data.cos_v;
      rx1_ff <= job_data.ref_x;
      ry1_ff <= job_data.ref_y;
      z1_ff  <= job_data.box_height;
      k1_ff  <= k_ff;
      if (q_wr) q_ff[qw_ff] <= r_in;
   end
endmodule

// ===== rtl/oriented_box_vertex_generator.sv =====
// ============================================================================
// oriented_box_vertex_generator
// Eight corners of an oriented box from reference point, heading and size.
// ============================================================================
// Usage:
//   Input queue: drive req_data and raise push; a transfer happens when
//   full is low. One box per transfer.
//   Output queue: while empty is low rsp_data holds the oldest corner;
//   raise pop to take it. Corners come in order 0..7, last set on 7.
//   Path: 30 CORDIC stages, one classify stage, the job queue, then a
//   multiply stage and the result queue that the place logic writes.
//   Throughput: one corner per cycle while the result queue has room; the
//   emitter finishes one box before it takes the next. The front accepts a box per
//   cycle until the 4-entry job queue fills, then full rises.
//   Reset clears all queues and pipeline valid flags; no clearing pass.
//   When the receiver stalls, the result queue fills (three corners), the
//   emitter holds its corner count, and backpressure reaches full in turn.
// ============================================================================
module oriented_box_vertex_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  obvg_pkg::req_type  req_data,
   output logic               empty,
   input  logic               pop,
   output obvg_pkg::rsp_type  rsp_data
);
   import obvg_pkg::*;

   logic    f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   obvg_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data(req_data), .job_valid(f_valid), .job_ready(f_ready),
      .job_data(f_job)
   );

   obvg_job_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
   );

   obvg_back u_back (
      .clock(clock), .reset(reset), .job_valid(b_valid), .job_ready(b_ready),
      .job_data(b_job), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );
endmodule

// ===== rtl/obvg_checker.sv =====
// ============================================================================
// obvg_checker
// Port-level checks on corner order and output queue behavior.
// ============================================================================
module obvg_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  logic               pop,
   input  obvg_pkg::rsp_type  rsp_data
);
   import obvg_pkg::*;

   // last marks exactly the eighth corner
   a_last: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.last == (rsp_data.vertex_index == 3'd7)))
      else $error("last flag mismatch");

   // bottom corners sit at zero height
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.vertex_index[2]) |-> (rsp_data.vertex_z == 16'd0))
      else $error("bottom corner height nonzero");

   // a held corner stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // next corner follows in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop) ##1 !empty |->
         rsp_data.vertex_index == $past(rsp_data.vertex_index) + 3'd1)
      else $error("corner out of order");
endmodule

bind oriented_box_vertex_generator obvg_checker u_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop), .rsp_data(rsp_data)
);

// ===== bench/tb_oriented_box_vertex_generator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_oriented_box_vertex_generator
// Drives boxes into the corner generator through its input queue and checks
// every corner against a CORDIC-based corner predictor, with random idling
// on both sides.
// ============================================================================
module tb_oriented_box_vertex_generator;
   import obvg_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_BOXES   = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   req_type pending_boxes[$];
   rsp_type expected_corners[$];
   int      error_count = 0;
   int      idle_count  = 0;
   bit      calm_mode   = 1'b0;
   bit      stim_done   = 1'b0;

   oriented_box_vertex_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   // arctangent steps in 2^-32 turn
   function automatic longint atan_step(input int i);
      longint steps[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
         20, 10, 5, 3, 1};
      return steps[i];
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rotate the gain-compensated unit vector to the heading
   function automatic void heading_cos_sin(input logic [15:0] hd, output longint c,
                                           output longint s);
      logic [31:0] turn;
      longint      x, y, z, xs, ys, cc, ss;
      turn = {hd, 16'h0000};
      x = 652032874;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < 30; i++) begin
         xs = y >>> i;
         ys = x >>> i;
         if (z >= 0) begin
            x -= xs; y += ys; z -= atan_step(i);
         end else begin
            x += xs; y -= ys; z += atan_step(i);
         end
      end
      case (turn[31:30])
         2'd0: begin cc = x;  ss = y;  end
         2'd1: begin cc = -y; ss = x;  end
         2'd2: begin cc = -x; ss = -y; end
         default: begin cc = y; ss = -x; end
      endcase
      c = clip(cc, -1073741824, 1073741824);
      s = clip(ss, -1073741824, 1073741824);
   endfunction

   function automatic logic [31:0] offset_coord(input longint base, input longint prod);
      longint d;
      longint lim;
      lim = longint'(1) << 31;
      d = (prod + (longint'(1) << 30)) >>> 31;
      return 32'(clip(base + d, -lim, lim - 1));
   endfunction

   // append one box to the stimulus queue
   function automatic void add_box(input req_type b);
      pending_boxes.insert(pending_boxes.size(), b);
   endfunction

   // queue the eight expected corners of one box
   function automatic void predict_corners(input req_type b);
      longint  c, s, sf, sr, w;
      longint  sv[4], tv[4];
      rsp_type r;
      heading_cos_sin(b.heading, c, s);
      w = longint'(b.box_width);
      if (b.kind == 1'b0) begin
         sf = longint'(b.box_length);
         sr = -longint'(b.box_length);
      end else begin
         sf = 2 * longint'(b.front_overhang);
         sr = 2 * (longint'(b.front_overhang) - longint'(b.box_length));
      end
      sv = '{sf, sf, sr, sr};
      tv = '{w, -w, -w, w};
      for (int k = 0; k < 8; k++) begin
         r.vertex_x     = offset_coord(longint'(b.ref_x), sv[k%4] * c - tv[k%4] * s);
         r.vertex_y     = offset_coord(longint'(b.ref_y), sv[k%4] * s + tv[k%4] * c);
         r.vertex_z     = (k < 4) ? 16'd0 : b.box_height;
         r.vertex_index = 3'(k);
         r.last         = (k == 7);
         expected_corners.insert(expected_corners.size(), r);
      end
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 3));
         1: return 16'hFFFF - 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF - 32'($urandom_range(0, 40000));
         1: return 32'h8000_0000 + 32'($urandom_range(0, 40000));
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic req_type make_box(input logic k, input logic [31:0] rx,
                                        input logic [31:0] ry, input logic [15:0] hd,
                                        input logic [15:0] l, input logic [15:0] w,
                                        input logic [15:0] a, input logic [15:0] h);
      req_type b;
      b = '{k, rx, ry, hd, l, w, a, h};
      return b;
   endfunction

   // fill the stimulus queue: directed boxes first, then random ones
   initial begin
      add_box(make_box(1'b0, 32'd0, 32'd0, 16'h0000, 16'd4096, 16'd2048, 16'd0,
                       16'd1536));
      add_box(make_box(1'b1, 32'd0, 32'd0, 16'h4000, 16'd4096, 16'd2048, 16'd1024,
                       16'hFFFF));
      add_box(make_box(1'b0, 32'd1000, -32'sd1000, 16'h8000, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'd0));
      add_box(make_box(1'b1, 32'd0, 32'd0, 16'hC000, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1));
      add_box(make_box(1'b1, 32'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
      // overhang beyond length under front reference
      add_box(make_box(1'b1, 32'd5000, 32'd7000, 16'h2000, 16'd100, 16'd300,
                       16'hFFFF, 16'd77));
      // coordinates saturating at both ends
      add_box(make_box(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'hFFFF,
                       16'hFFFF, 16'd0, 16'd0));
      add_box(make_box(1'b0, 32'h8000_0000, 32'h8000_0000, 16'hA000, 16'hFFFF,
                       16'hFFFF, 16'd0, 16'd0));
      add_box(make_box(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h6000, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'hFFFF));
      add_box(make_box(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hE000, 16'hFFFF,
                       16'hFFFF, 16'd0, 16'h5555));
      add_box(make_box(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 16'd3,
                       16'd1, 16'd2, 16'hAAAA));
      add_box(make_box(1'b0, 32'd0, 32'd0, 16'h4001, 16'd1, 16'd1, 16'd0, 16'd0));
      add_box(make_box(1'b1, 32'd0, 32'd0, 16'h7FFF, 16'd1, 16'd1, 16'd1, 16'd0));
      for (int n = 0; n < RANDOM_BOXES; n++) begin
         add_box(make_box(1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                          16'($urandom), pick_size(), pick_size(),
                          pick_size(), 16'($urandom)));
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // hold a long stretch with no idling in the middle of the run
   always @(posedge clock) begin
      calm_mode <= (pending_boxes.size() > 120 && pending_boxes.size() < 200);
   end

   // driver: present the next box, advance on a transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            void'(pending_boxes.pop_front());
         end
         if (pending_boxes.size() != 0 && (calm_mode || $urandom_range(0, 99) >= 16)) begin
            if (!(push && !full) || pending_boxes.size() > 0) begin
               req_data <= pending_boxes[0];
               push     <= 1'b1;
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // predict on every input transfer
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         predict_corners(req_data);
      end
   end

   // monitor: compare each corner transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_corners.size() == 0) begin
               $display("%0t: unexpected corner %p", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_corners.pop_front();
               if (rsp_data.vertex_x !== want.vertex_x)
                  $display("%0t: vertex_x expected %0d actual %0d", $time, want.vertex_x,
                           rsp_data.vertex_x);
               if (rsp_data.vertex_y !== want.vertex_y)
                  $display("%0t: vertex_y expected %0d actual %0d", $time, want.vertex_y,
                           rsp_data.vertex_y);
               if (rsp_data.vertex_z !== want.vertex_z)
                  $display("%0t: vertex_z expected %0d actual %0d", $time, want.vertex_z,
                           rsp_data.vertex_z);
               if (rsp_data.vertex_index !== want.vertex_index)
                  $display("%0t: vertex_index expected %0d actual %0d", $time,
                           want.vertex_index, rsp_data.vertex_index);
               if (rsp_data.last !== want.last)
                  $display("%0t: last expected %0d actual %0d", $time, want.last,
                           rsp_data.last);
               if (rsp_data !== want) error_count++;
            end
         end
         pop <= calm_mode || $urandom_range(0, 99) >= 16;
      end
   end

   // watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // end of run: drain, then settle
   initial begin
      while (reset) @(posedge clock);
      while (pending_boxes.size() != 0 || push) @(posedge clock);
      while (expected_corners.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_corners.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
